// ===== design/hpt_pkg.sv =====
`timescale 1ns / 1ps

package hpt_pkg;

  // Quotient bits of the radius division: 32-bit alpha shifted up by 14
  localparam int DIV_BITS = 46;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [31:0] ALPHA_RESET = 32'd14573637;
  localparam logic [29:0] KGAIN_Q30   = 30'd652032874;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [40:0] TERM_CAP    = 41'd1 << 40;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_CURV = 2'd1;
  localparam logic [1:0] ST_CENTRE    = 2'd2;
  localparam logic [1:0] ST_SAT       = 2'd3;

  // atan(2^-i) as a fraction of a 32-bit turn
  localparam logic [31:0] ATAN_TURNS [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0
  };

  // Everything one transaction carries down the pipeline
  typedef struct packed {
    logic signed [31:0]   dr;
    logic signed [31:0]   dz;
    logic signed [31:0]   tl;
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic signed [31:0]   pz;
    logic signed [31:0]   nx;
    logic signed [31:0]   ny;
    logic signed [31:0]   nz;
    logic [15:0]          az_in;
    logic [31:0]          az;
    logic                 kzero;
    logic                 kneg;
    logic [DIV_BITS-1:0]  dn;
    logic [DIV_BITS-1:0]  dq;
    logic [31:0]          rem;
    logic [31:0]          dvs;
    logic signed [47:0]   r;
    logic [1:0]           quad;
    logic signed [33:0]   rx;
    logic signed [33:0]   ry;
    logic signed [33:0]   rz;
    logic [46:0]          sm;
    logic                 sneg;
    logic [31:0]          cm;
    logic [31:0]          snm;
    logic                 cneg;
    logic                 snneg;
    logic [78:0]          pc;
    logic [78:0]          ps;
    logic signed [49:0]   ex;
    logic signed [49:0]   ey;
    logic signed [49:0]   vx;
    logic signed [49:0]   vy;
    logic                 degen;
    logic [48:0]          vm;
    logic [4:0]           down;
    logic [4:0]           up;
    logic signed [35:0]   cx;
    logic signed [35:0]   cy;
    logic [31:0]          vz;
    logic [34:0]          g;
    logic [55:0]          mag;
    logic [31:0]          phin;
    logic signed [57:0]   drp;
    logic signed [57:0]   dzp;
    logic signed [31:0]   d;
    logic                 tneg;
    logic [55:0]          tu;
    logic [87:0]          tw;
    logic [47:0]          tp;
    logic [45:0]          rm;
    logic [93:0]          tacc;
  } item_t;

endpackage

// ===== design/helix_pivot_transform.sv =====
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// config    cfg_we_i             cfg_wdata_i (alpha_scale)
// input     start && !busy       dist_r_i .. target_z_i
// result    done_o (one cycle)   new_dist_r_o, new_azimuth_o, new_dist_z_o, status_o
//
// One transaction enters every cycle; busy never rises.
// Each transaction passes through the 46-step radius divider and the rotation
// and vectoring CORDIC chains.
// Reset clears the valid line and restores alpha_scale; the receiver cannot
// stall, so the pipeline always advances.
module helix_pivot_transform #(
  parameter int ANGLE_BITS    = hpt_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = hpt_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] dist_r_i,
  input  logic [15:0]        azimuth_i,
  input  logic signed [31:0] curvature_i,
  input  logic signed [31:0] dist_z_i,
  input  logic signed [31:0] dip_slope_i,
  input  logic signed [31:0] ref_x_i,
  input  logic signed [31:0] ref_y_i,
  input  logic signed [31:0] ref_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  output logic               done_o,
  output logic signed [31:0] new_dist_r_o,
  output logic [15:0]        new_azimuth_o,
  output logic signed [31:0] new_dist_z_o,
  output logic [1:0]         status_o
);
  import hpt_pkg::*;

  localparam int LAT = DIV_BITS + 2 * CORDIC_STAGES + 25;
  localparam int PSHIFT = 32 - ANGLE_BITS;
  localparam logic [31:0] AMASK = (32'd1 << ANGLE_BITS) - 32'd1;
  localparam logic [31:0] HALF  = 32'd1 << (ANGLE_BITS - 1);
  localparam logic [31:0] RND   = 32'd1 << (31 - ANGLE_BITS);
  localparam logic [48:0] M31   = 49'd1 << 31;
  localparam logic [48:0] M30   = 49'd1 << 30;
  localparam logic signed [57:0] MAX32 = 58'sd2147483647;
  localparam logic signed [57:0] MIN32 = -58'sd2147483648;

  logic            accept;
  logic [31:0]     alpha_q;
  logic [LAT-1:0]  vld_q;

  item_t a_d, a_q, dv, b_d, b_q, c_d, c_q, m1_d, m1_q, m2_d, m2_q;
  item_t e_d, e_q, f_d, f_q, g0_d, g0_q;
  item_t h1_d, h1_q, h2_d, h2_q, h3_d, h3_q, h4_d, h4_q, h5_d, h5_q;
  item_t h6_d, h6_q, h7_d, h7_q, h8_d, h8_q, h9_d, h9_q, h10_d, h10_q;
  item_t h11_d, h11_q;
  item_t rot_q [CORDIC_STAGES];
  item_t nrm_q [5];
  item_t vec_q [CORDIC_STAGES];

  logic signed [31:0] out_dr_d, out_dr_q, out_dz_d, out_dz_q;
  logic [15:0]        out_az_d, out_az_q;
  logic [1:0]         out_st_d, out_st_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // config register and valid line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      vld_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        alpha_q <= cfg_wdata_i;
      end
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // capture, set up the radius division
  always_comb begin
    a_d       = '0;
    a_d.dr    = dist_r_i;
    a_d.dz    = dist_z_i;
    a_d.tl    = dip_slope_i;
    a_d.px    = ref_x_i;
    a_d.py    = ref_y_i;
    a_d.pz    = ref_z_i;
    a_d.nx    = target_x_i;
    a_d.ny    = target_y_i;
    a_d.nz    = target_z_i;
    a_d.az_in = azimuth_i;
    a_d.az    = {16'd0, azimuth_i} & AMASK;
    a_d.kzero = (curvature_i == '0);
    a_d.kneg  = curvature_i[31];
    a_d.dvs   = curvature_i[31] ? (32'd0 - curvature_i) : curvature_i;
    a_d.dn    = {alpha_q, 14'd0};
  end

  hpt_div u_div (
    .clk_i  (clk_i),
    .item_i (a_q),
    .item_o (dv)
  );

  // signed radius, rotation start vector
  always_comb begin
    logic [31:0] ang;
    b_d     = dv;
    b_d.r   = dv.kneg ? -$signed({2'b0, dv.dq}) : $signed({2'b0, dv.dq});
    ang     = dv.az << PSHIFT;
    b_d.quad = ang[31:30];
    b_d.rz  = $signed({4'b0, ang[29:0]});
    b_d.rx  = $signed({4'b0, KGAIN_Q30});
    b_d.ry  = '0;
  end

  // rotation CORDIC: cos and sin of phi0
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
    item_t src;
    item_t nxt;
    if (i == 0) begin : g_first
      assign src = b_q;
    end else begin : g_next
      assign src = rot_q[i-1];
    end
    always_comb begin
      logic signed [33:0] at;
      nxt = src;
      at  = $signed({2'b0, ATAN_TURNS[i]});
      if (!src.rz[33]) begin
        nxt.rx = src.rx - (src.ry >>> i);
        nxt.ry = src.ry + (src.rx >>> i);
        nxt.rz = src.rz - at;
      end else begin
        nxt.rx = src.rx + (src.ry >>> i);
        nxt.ry = src.ry - (src.rx >>> i);
        nxt.rz = src.rz + at;
      end
    end
    always_ff @(posedge clk_i) begin
      rot_q[i] <= nxt;
    end
  end

  // quadrant fold, magnitudes for the products
  always_comb begin
    logic signed [33:0] cv, sv, ca, sa;
    logic signed [47:0] sum, su;
    c_d = rot_q[CORDIC_STAGES-1];
    case (c_d.quad)
      2'd0: begin
        cv = c_d.rx;  sv = c_d.ry;
      end
      2'd1: begin
        cv = -c_d.ry; sv = c_d.rx;
      end
      2'd2: begin
        cv = -c_d.rx; sv = -c_d.ry;
      end
      default: begin
        cv = c_d.ry;  sv = -c_d.rx;
      end
    endcase
    ca       = cv[33] ? -cv : cv;
    sa       = sv[33] ? -sv : sv;
    sum      = c_d.dr + c_d.r;
    su       = sum[47] ? -sum : sum;
    c_d.cneg  = cv[33];
    c_d.snneg = sv[33];
    c_d.cm    = ca[31:0];
    c_d.snm   = sa[31:0];
    c_d.sneg  = sum[47];
    c_d.sm    = su[46:0];
  end

  // (dr + r) * cos / sin, low half
  always_comb begin
    logic [55:0] ppc, pps;
    m1_d    = c_q;
    ppc     = c_q.sm[23:0] * c_q.cm;
    pps     = c_q.sm[23:0] * c_q.snm;
    m1_d.pc = {23'd0, ppc};
    m1_d.ps = {23'd0, pps};
  end

  // high half
  always_comb begin
    logic [54:0] ppc, pps;
    m2_d    = m1_q;
    ppc     = m1_q.sm[46:24] * m1_q.cm;
    pps     = m1_q.sm[46:24] * m1_q.snm;
    m2_d.pc = m1_q.pc + {ppc, 24'd0};
    m2_d.ps = m1_q.ps + {pps, 24'd0};
  end

  // centre relative to the new point
  always_comb begin
    logic signed [49:0] prc, prs;
    e_d = m2_q;
    prc = $signed({1'b0, m2_q.pc[78:30]});
    prs = $signed({1'b0, m2_q.ps[78:30]});
    if (m2_q.cneg ^ m2_q.sneg) begin
      prc = -prc;
    end
    if (m2_q.snneg ^ m2_q.sneg) begin
      prs = -prs;
    end
    e_d.ex = m2_q.px + prc - m2_q.nx;
    e_d.ey = m2_q.py + prs - m2_q.ny;
  end

  // degenerate check, oriented vector and its largest component
  always_comb begin
    logic signed [49:0] ax, ay;
    f_d       = e_q;
    f_d.degen = (e_q.r == '0) || (e_q.ex == '0 && e_q.ey == '0);
    f_d.vx    = (e_q.r > 48'sd0) ? e_q.ex : -e_q.ex;
    f_d.vy    = (e_q.r > 48'sd0) ? e_q.ey : -e_q.ey;
    ax        = f_d.vx[49] ? -f_d.vx : f_d.vx;
    ay        = f_d.vy[49] ? -f_d.vy : f_d.vy;
    f_d.vm    = (ax > ay) ? ax[48:0] : ay[48:0];
    f_d.down  = '0;
    f_d.up    = '0;
  end

  // normalise the largest component into [2^30, 2^31), 16/8/4/2/1 steps
  for (genvar k = 0; k < 5; k++) begin : g_nrm
    localparam int SH = 16 >> k;
    item_t src;
    item_t nxt;
    if (k == 0) begin : g_first
      assign src = f_q;
    end else begin : g_next
      assign src = nrm_q[k-1];
    end
    always_comb begin
      nxt = src;
      if (src.vm >= M31 && (src.vm >> SH) >= M30) begin
        nxt.vm   = src.vm >> SH;
        nxt.vx   = src.vx >>> SH;
        nxt.vy   = src.vy >>> SH;
        nxt.down = src.down + 5'(SH);
      end else if (src.vm < M30 && (src.vm << SH) < M31) begin
        nxt.vm   = src.vm << SH;
        nxt.vx   = src.vx <<< SH;
        nxt.vy   = src.vy <<< SH;
        nxt.up   = src.up + 5'(SH);
      end
    end
    always_ff @(posedge clk_i) begin
      nrm_q[k] <= nxt;
    end
  end

  // fold into the right half-plane
  always_comb begin
    logic signed [35:0] tx, ty;
    g0_d = nrm_q[4];
    tx   = {{2{nrm_q[4].vx[33]}}, nrm_q[4].vx[33:0]};
    ty   = {{2{nrm_q[4].vy[33]}}, nrm_q[4].vy[33:0]};
    if (tx[35]) begin
      g0_d.cx = -tx;
      g0_d.cy = -ty;
      g0_d.vz = 32'h8000_0000;
    end else begin
      g0_d.cx = tx;
      g0_d.cy = ty;
      g0_d.vz = '0;
    end
  end

  // vectoring CORDIC: angle and magnitude
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    item_t src;
    item_t nxt;
    if (i == 0) begin : g_first
      assign src = g0_q;
    end else begin : g_next
      assign src = vec_q[i-1];
    end
    always_comb begin
      nxt = src;
      if (!src.cy[35] && src.cy != '0) begin
        nxt.cx = src.cx + (src.cy >>> i);
        nxt.cy = src.cy - (src.cx >>> i);
        nxt.vz = src.vz + ATAN_TURNS[i];
      end else begin
        nxt.cx = src.cx - (src.cy >>> i);
        nxt.cy = src.cy + (src.cx >>> i);
        nxt.vz = src.vz - ATAN_TURNS[i];
      end
    end
    always_ff @(posedge clk_i) begin
      vec_q[i] <= nxt;
    end
  end

  // remove CORDIC gain
  always_comb begin
    logic [34:0] xp;
    logic [64:0] gp;
    h1_d  = vec_q[CORDIC_STAGES-1];
    xp    = h1_d.cx[35] ? '0 : h1_d.cx[34:0];
    gp    = xp * KGAIN_Q30;
    h1_d.g = gp[64:30];
  end

  // undo normalisation with rounding; round the angle
  always_comb begin
    logic [55:0] gs;
    h2_d = h1_q;
    gs   = {21'd0, h1_q.g} << h1_q.down;
    if (h1_q.up != '0) begin
      gs = (gs + (56'd1 << (h1_q.up - 5'd1))) >> h1_q.up;
    end
    h2_d.mag  = gs;
    h2_d.phin = ((h1_q.vz + RND) >> PSHIFT) & AMASK;
  end

  // new distance, wrapped azimuth change
  always_comb begin
    logic signed [57:0] smag;
    logic [31:0]        ph, dd;
    h3_d = h2_q;
    smag = $signed({2'b0, h2_q.mag});
    if (h2_q.degen) begin
      h3_d.drp = h2_q.ex - h2_q.r;
      ph       = '0;
    end else begin
      h3_d.drp = ((h2_q.r > 48'sd0) ? smag : -smag) - h2_q.r;
      ph       = h2_q.phin;
    end
    h3_d.phin = ph;
    dd        = (ph - h2_q.az) & AMASK;
    h3_d.d    = (dd > HALF) ? $signed(dd - (32'd1 << ANGLE_BITS)) : $signed(dd);
  end

  // |tanl| * |dphi|
  always_comb begin
    logic [31:0] dm, tlm;
    h4_d      = h3_q;
    dm        = h3_q.d[31] ? (32'd0 - h3_q.d) : h3_q.d;
    tlm       = h3_q.tl[31] ? (32'd0 - h3_q.tl) : h3_q.tl;
    h4_d.tu   = tlm * dm[23:0];
    h4_d.tneg = h3_q.r[47] ^ (h3_q.tl[31] ^ h3_q.d[31]);
  end

  // times pi, low part
  always_comb begin
    logic [59:0] pw;
    h5_d    = h4_q;
    pw      = h4_q.tu[27:0] * PI_Q30;
    h5_d.tw = {28'd0, pw};
  end

  // times pi, high part
  always_comb begin
    logic [59:0] pw;
    h6_d    = h5_q;
    pw      = h5_q.tu[55:28] * PI_Q30;
    h6_d.tw = h5_q.tw + {pw, 28'd0};
  end

  // scale to Q30, start |r| * tp
  always_comb begin
    logic [87:0]        sh;
    logic signed [47:0] ra;
    logic [46:0]        p;
    h7_d      = h6_q;
    sh        = h6_q.tw >> (ANGLE_BITS + 15);
    ra        = h6_q.r[47] ? -h6_q.r : h6_q.r;
    h7_d.tp   = sh[47:0];
    h7_d.rm   = ra[45:0];
    p         = ra[22:0] * sh[23:0];
    h7_d.tacc = {47'd0, p};
  end

  always_comb begin
    logic [46:0] p;
    h8_d      = h7_q;
    p         = h7_q.rm[22:0] * h7_q.tp[47:24];
    h8_d.tacc = h7_q.tacc + {23'd0, p, 24'd0};
  end

  always_comb begin
    logic [46:0] p;
    h9_d      = h8_q;
    p         = h8_q.rm[45:23] * h8_q.tp[23:0];
    h9_d.tacc = h8_q.tacc + {24'd0, p, 23'd0};
  end

  always_comb begin
    logic [46:0] p;
    h10_d      = h9_q;
    p          = h9_q.rm[45:23] * h9_q.tp[47:24];
    h10_d.tacc = h9_q.tacc + {p, 47'd0};
  end

  // capped term, new z offset
  always_comb begin
    logic [63:0]        tq;
    logic [40:0]        tmv;
    logic signed [57:0] term;
    h11_d = h10_q;
    tq    = h10_q.tacc[93:30];
    tmv   = (tq > {23'd0, TERM_CAP}) ? TERM_CAP : tq[40:0];
    term  = $signed({17'd0, tmv});
    if (h10_q.tneg) begin
      term = -term;
    end
    h11_d.dzp = h10_q.pz + h10_q.dz - term - h10_q.nz;
  end

  // saturation and status
  always_comb begin
    logic sat_r, sat_z;
    sat_r = (h11_q.drp > MAX32) || (h11_q.drp < MIN32);
    sat_z = (h11_q.dzp > MAX32) || (h11_q.dzp < MIN32);
    if (h11_q.kzero) begin
      out_dr_d = h11_q.dr;
      out_az_d = h11_q.az_in;
      out_dz_d = h11_q.dz;
      out_st_d = ST_ZERO_CURV;
    end else begin
      out_dr_d = sat_r ? (h11_q.drp[57] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                       : h11_q.drp[31:0];
      out_dz_d = sat_z ? (h11_q.dzp[57] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                       : h11_q.dzp[31:0];
      out_az_d = h11_q.phin[15:0];
      if (sat_r || sat_z) begin
        out_st_d = ST_SAT;
      end else if (h11_q.degen) begin
        out_st_d = ST_CENTRE;
      end else begin
        out_st_d = ST_OK;
      end
    end
  end

  // payload stage registers
  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    m1_q     <= m1_d;
    m2_q     <= m2_d;
    e_q      <= e_d;
    f_q      <= f_d;
    g0_q     <= g0_d;
    h1_q     <= h1_d;
    h2_q     <= h2_d;
    h3_q     <= h3_d;
    h4_q     <= h4_d;
    h5_q     <= h5_d;
    h6_q     <= h6_d;
    h7_q     <= h7_d;
    h8_q     <= h8_d;
    h9_q     <= h9_d;
    h10_q    <= h10_d;
    h11_q    <= h11_d;
    out_dr_q <= out_dr_d;
    out_dz_q <= out_dz_d;
    out_az_q <= out_az_d;
    out_st_q <= out_st_d;
  end

  assign done_o        = vld_q[LAT-1];
  assign new_dist_r_o  = out_dr_q;
  assign new_azimuth_o = out_az_q;
  assign new_dist_z_o  = out_dz_q;
  assign status_o      = out_st_q;

  // every transaction yields exactly one result after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> ##LAT done_o)
    else $error("result missing after accepted transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(accept, LAT))
    else $error("result without a transaction");

  // zero curvature returns the azimuth untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_ZERO_CURV |-> new_azimuth_o == $past(azimuth_i, LAT))
    else $error("zero curvature azimuth altered");

  // undefined direction reports angle zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_CENTRE |-> new_azimuth_o == '0)
    else $error("centre case with nonzero azimuth");

endmodule

// ===== design/hpt_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, dn / dvs -> dq
module hpt_div (
  input  logic           clk_i,
  input  hpt_pkg::item_t item_i,
  output hpt_pkg::item_t item_o
);
  import hpt_pkg::*;

  item_t st_q [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
    item_t       src;
    item_t       nxt;
    logic [32:0] rem_sh;

    if (k == 0) begin : g_first
      assign src = item_i;
    end else begin : g_next
      assign src = st_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      nxt    = src;
      rem_sh = {src.rem, src.dn[DIV_BITS-1]};
      nxt.dn = {src.dn[DIV_BITS-2:0], 1'b0};
      if (rem_sh >= {1'b0, src.dvs}) begin
        rem_sh  = rem_sh - {1'b0, src.dvs};
        nxt.dq  = {src.dq[DIV_BITS-2:0], 1'b1};
      end else begin
        nxt.dq  = {src.dq[DIV_BITS-2:0], 1'b0};
      end
      nxt.rem = rem_sh[31:0];
    end

    always_ff @(posedge clk_i) begin
      st_q[k] <= nxt;
    end
  end

  assign item_o = st_q[DIV_BITS-1];

endmodule
